// File: rtl/periodic_timer_table_macros.svh
// assertion macros for the periodic timer table checker
// depends on clk and rst_n in the scope of each use
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// concurrent assertion clocked on clk, off during reset
`define PTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also runs during reset
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ptt_pkg.sv
// shared constants for the periodic timer table
// no dependencies
package ptt_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int MAX_FIRE    = 16;

  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 2;
  localparam int TIME_W   = 32;
  localparam int WAIT_W   = 16;

  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

// File: rtl/ptt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/periodic_timer_table.sv
// periodic timer table: add, delete, re-time and tick over ENTRIES slots
// tick: min(fires+1, MAX_FIRE) scan passes over the entries, one wait pass, then one
// word per fire (a single word when nothing fired); one item at a time
// reset (synchronous, rst_n low) clears used bits, time and stamp counters
// depends on ptt_pkg and ptt_ram
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [PERIOD_W-1:0] in_period,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_handle,
  output logic                out_fired,
  output logic                out_last,
  output logic [WAIT_W-1:0]   out_wait_seconds
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;
  localparam int FW = $clog2(MAX_FIRE) + 1;
  localparam int OW = $clog2(MAX_FIRE);
  localparam int DW = TIME_W + PERIOD_W + TIME_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_SCAN, S_PICK, S_WSCAN, S_EMIT, S_RESP
  } st_t;

  st_t state_r;

  // control state
  logic [ENTRIES-1:0] used_r;
  logic [ENTRIES-1:0] done_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  stamp_r;
  logic [CW-1:0]      cnt_r;
  logic               pv_r;
  logic [IW-1:0]      pidx_r;
  logic               found_r;
  logic               have_r;
  logic [FW-1:0]      n_r;
  logic [FW-1:0]      k_r;
  logic               out_valid_r;

  // payload registers
  logic [IW-1:0]       bidx_r;
  logic [TIME_W-1:0]   bexp_r;
  logic [TIME_W-1:0]   bstamp_r;
  logic [PERIOD_W-1:0] bper_r;
  logic [TIME_W-1:0]   wbest_r;
  logic [IW-1:0]       order_r [MAX_FIRE];
  logic [STATUS_W-1:0] resp_status_r;
  logic [SLOT_W-1:0]   resp_handle_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_handle_r;
  logic                out_fired_r;
  logic                out_last_r;
  logic [WAIT_W-1:0]   out_wait_r;

  // entry ram: {expiry, period, stamp}
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  ptt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  logic [TIME_W-1:0] rd_exp;
  logic [TIME_W-1:0] rd_stamp;
  assign rd_exp   = ram_rdata[DW-1 -: TIME_W];
  assign rd_stamp = ram_rdata[TIME_W-1:0];

  logic          accept;
  logic [IW-1:0] slot_idx;
  logic          slot_bad;
  logic [IW-1:0] add_idx;
  assign accept   = in_valid && in_ready;
  assign slot_idx = IW'(in_slot);
  assign slot_bad = (32'(in_slot) >= ENTRIES) || !used_r[slot_idx];
  assign add_idx  = cnt_r[IW-1:0];

  // scan compare on the word coming back from the ram
  logic              fire_hit;
  logic              fire_better;
  logic              wait_hit;
  logic [TIME_W-1:0] wait_d;
  logic              wait_better;
  always_comb begin
    fire_hit    = pv_r && used_r[pidx_r] && !done_r[pidx_r] && (rd_exp <= now_r);
    fire_better = !found_r || (rd_exp < bexp_r) ||
                  ((rd_exp == bexp_r) && (rd_stamp < bstamp_r));
    wait_hit    = pv_r && used_r[pidx_r] && (rd_exp > now_r);
    wait_d      = rd_exp - now_r;
    wait_better = !have_r || (wait_d < wbest_r);
  end

  // wait value: 1 when nothing pending, saturated to 16 bits
  logic [WAIT_W-1:0] wait_val;
  always_comb begin
    if (!have_r) begin
      wait_val = WAIT_W'(1);
    end else if (wbest_r > TIME_W'({WAIT_W{1'b1}})) begin
      wait_val = {WAIT_W{1'b1}};
    end else begin
      wait_val = wbest_r[WAIT_W-1:0];
    end
  end

  // ram writes: re-time at accept, add on the free slot, reschedule on a fire
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_idx;
    ram_wdata = {now_r + TIME_W'(in_period), in_period, stamp_r};
    unique case (state_r)
      S_IDLE: begin
        ram_we = accept && (in_mode == MODE_SET) && !slot_bad;
      end
      S_ADD: begin
        // period was captured at accept, the input may have moved on
        ram_we    = !used_r[add_idx];
        ram_waddr = add_idx;
        ram_wdata = {now_r + TIME_W'(bper_r), bper_r, stamp_r};
      end
      S_PICK: begin
        ram_we    = found_r;
        ram_waddr = bidx_r;
        ram_wdata = {now_r + TIME_W'(bper_r), bper_r, stamp_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_r || out_ready;
  // a new word goes into the output register this cycle
  assign out_load = out_free && ((state_r == S_EMIT) || (state_r == S_RESP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      done_r      <= '0;
      now_r       <= '0;
      stamp_r     <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      pidx_r      <= '0;
      found_r     <= 1'b0;
      have_r      <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r) inside
        S_IDLE: begin
          if (accept) begin
            cnt_r <= '0;
            pv_r  <= 1'b0;
            case (in_mode) inside
              MODE_ADD: begin
                bper_r  <= in_period;
                state_r <= S_ADD;
              end
              MODE_DEL, MODE_SET: begin
                state_r <= S_RESP;
                if (slot_bad) begin
                  resp_status_r <= ST_BAD;
                  resp_handle_r <= '0;
                end else begin
                  resp_status_r <= ST_OK;
                  resp_handle_r <= in_slot;
                  if (in_mode == MODE_DEL) begin
                    used_r[slot_idx] <= 1'b0;
                  end else begin
                    stamp_r <= stamp_r + 1'b1;
                  end
                end
              end
              default: begin
                // tick: advance time, start the first fire pass
                now_r   <= now_r + 1'b1;
                done_r  <= '0;
                n_r     <= '0;
                found_r <= 1'b0;
                state_r <= S_SCAN;
              end
            endcase
          end
        end
        S_ADD: begin
          // lowest free slot, one used bit per cycle
          if (!used_r[add_idx]) begin
            used_r[add_idx] <= 1'b1;
            stamp_r         <= stamp_r + 1'b1;
            resp_status_r   <= ST_OK;
            resp_handle_r   <= SLOT_W'(add_idx);
            state_r         <= S_RESP;
          end else if (cnt_r == CW'(ENTRIES - 1)) begin
            resp_status_r <= ST_FULL;
            resp_handle_r <= '0;
            state_r       <= S_RESP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SCAN, S_WSCAN: begin
          pv_r   <= (cnt_r < CW'(ENTRIES));
          pidx_r <= cnt_r[IW-1:0];
          if (cnt_r < CW'(ENTRIES)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (state_r == S_SCAN) begin
            if (fire_hit && fire_better) begin
              found_r  <= 1'b1;
              bidx_r   <= pidx_r;
              bexp_r   <= rd_exp;
              bstamp_r <= rd_stamp;
              bper_r   <= ram_rdata[TIME_W +: PERIOD_W];
            end
            if (cnt_r == CW'(ENTRIES)) begin
              state_r <= S_PICK;
            end
          end else begin
            if (wait_hit && wait_better) begin
              have_r  <= 1'b1;
              wbest_r <= wait_d;
            end
            if (cnt_r == CW'(ENTRIES)) begin
              k_r     <= '0;
              state_r <= S_EMIT;
            end
          end
        end
        S_PICK: begin
          cnt_r   <= '0;
          pv_r    <= 1'b0;
          found_r <= 1'b0;
          have_r  <= 1'b0;
          if (found_r) begin
            done_r[bidx_r]     <= 1'b1;
            order_r[n_r[OW-1:0]] <= bidx_r;
            n_r                <= n_r + 1'b1;
            stamp_r            <= stamp_r + 1'b1;
            state_r <= (n_r == FW'(MAX_FIRE - 1)) ? S_WSCAN : S_SCAN;
          end else begin
            state_r <= S_WSCAN;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_wait_r   <= wait_val;
            if (n_r == '0) begin
              out_handle_r <= '0;
              out_fired_r  <= 1'b0;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              out_handle_r <= SLOT_W'(order_r[k_r[OW-1:0]]);
              out_fired_r  <= 1'b1;
              out_last_r   <= (k_r == n_r - 1'b1);
              k_r          <= k_r + 1'b1;
              if (k_r == n_r - 1'b1) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= resp_status_r;
            out_handle_r <= resp_handle_r;
            out_fired_r  <= 1'b0;
            out_last_r   <= 1'b1;
            out_wait_r   <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_handle       = out_handle_r;
  assign out_fired        = out_fired_r;
  assign out_last         = out_last_r;
  assign out_wait_seconds = out_wait_r;

endmodule

// File: rtl/ptt_checker.sv
// port-level checker for the periodic timer table, bound to the top level
// depends on ptt_pkg and periodic_timer_table_macros.svh
`include "periodic_timer_table_macros.svh"

module ptt_checker
  import ptt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [SLOT_W-1:0]   out_handle,
  input logic                out_fired,
  input logic                out_last
);

  `PTT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out word dropped")
  `PTT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_handle) && $stable(out_status), "stalled out word changed")
  `PTT_ASSERT(a_fire_ok, out_valid && out_fired |-> out_status == ST_OK, "fired word with error status")
  `PTT_ASSERT(a_err_last, out_valid && out_status != ST_OK |-> out_last && !out_fired && out_handle == '0, "error word malformed")
  `PTT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_handle (out_handle),
  .out_fired  (out_fired),
  .out_last   (out_last)
);
